// File: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// payload structs, operation codes and the memory port control bundle
// ----------------------------------------------------------------------------
package olt_pkg;

  // width of the entry count and the capacity register
  localparam int CNT_W = 7;
  // largest count the count field can hold
  localparam int CNT_MAX = 127;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [POS_W-1:0]   found_index;
    logic [VAL_W-1:0]   read_value;
    logic [CNT_W-1:0]   count;
  } out_t;

  // memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

// File: rtl/olt_ram.sv
// ----------------------------------------------------------------------------
// olt_ram: entry store of the ordered list table
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module olt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  olt_pkg::ram_ctl_t ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  import olt_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table: array-backed ordered list engine
// read, find, insert with shift up and delete with shift down over one ram
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one operation item;
//   out channel (out_valid_o/out_ready_i/out_data_o) returns one result
//   item per operation. cfg channel writes the capacity register, always
//   ready; write it only while the engine is idle.
// steps from the accept edge to the edge that raises out_valid_o:
//   read            decode (issues the ram read), read wait, done
//   find            decode, scan (one ram read per entry compared), done
//   insert/delete   decode, shift (one entry moved per cycle), fin, done
//   refused ops     decode, done (read, insert or delete failing its check)
//   done holds while the output register is full. in_ready_o rises with
//   out_valid_o, so the next item can be taken while the result still
//   waits. the scan and the shift walk the single ram read port one address
//   a cycle, with one address adder shared by find, insert and delete.
// reset: list empty, capacity 64. entry storage is not cleared; entries
//   past the count are never read.
// stall: a result waits in the output register while the next item is
//   taken; that item then holds in its final step until the register frees.
// ----------------------------------------------------------------------------
module ordered_list_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [olt_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  olt_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output olt_pkg::out_t             out_data_o
);
  import olt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  // depth as seen by the 7-bit count
  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_READW  = 7'b0000100,
    S_FIND   = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] cap_q;
  logic             out_valid_q, out_valid_d;
  logic             wr_pend_q, wr_pend_d;
  logic             chk_q, chk_d;

  // operation payload and working registers
  mode_e            mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0] dst_q, dst_d;        // walking index
  logic [CNT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]    wr_addr_q, wr_addr_d;
  logic             ok_q, ok_d;
  logic [POS_W-1:0] fidx_q, fidx_d;
  logic [VAL_W-1:0] rval_q, rval_d;
  out_t             out_q, out_d;

  // ram side
  ram_ctl_t         ram_ctl;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [WIDTH-1:0] ram_wdata;
  logic [WIDTH-1:0] ram_rdata;

  // shared index adder and limits
  logic             step_down;
  logic [CNT_W-1:0] nxt;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] pos_ext;
  logic             cont;

  assign step_down = (mode_q == MODE_INSERT);
  assign nxt       = dst_q + (step_down ? {CNT_W{1'b1}} : CNT_W'(1));
  assign lim       = (cap_q < LIMIT_MAX) ? cap_q : LIMIT_MAX;
  assign pos_ext   = {1'b0, pos_q};
  // insert walks down to position, delete walks up to count - 1
  assign cont      = step_down ? (dst_q > pos_ext) : (nxt < len_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    wr_pend_d   = wr_pend_q;
    chk_d       = chk_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    val_d       = val_q;
    dst_d       = dst_q;
    cmp_idx_d   = cmp_idx_q;
    wr_addr_d   = wr_addr_q;
    ok_d        = ok_q;
    fidx_d      = fidx_q;
    rval_d      = rval_q;
    out_d       = out_q;
    ram_ctl     = '0;
    ram_waddr   = wr_addr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = AW'(dst_q);

    // result taken by the receiver
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_data_i.mode;
          pos_d   = in_data_i.position;
          val_d   = WIDTH'(in_data_i.value);
          ok_d    = 1'b0;
          fidx_d  = '0;
          rval_d  = '0;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_DONE;
        case (mode_q)
          MODE_READ: begin
            if (pos_ext < len_q) begin
              ram_ctl.re = 1'b1;
              ram_raddr  = AW'(pos_ext);
              state_d    = S_READW;
            end
          end
          MODE_FIND: begin
            dst_d   = '0;
            chk_d   = 1'b0;
            state_d = S_FIND;
          end
          MODE_INSERT: begin
            if (pos_ext <= len_q && len_q < lim) begin
              dst_d     = len_q;
              wr_pend_d = 1'b0;
              state_d   = S_SHIFT;
            end
          end
          MODE_DELETE: begin
            if (pos_ext < len_q) begin
              dst_d     = pos_ext;
              wr_pend_d = 1'b0;
              state_d   = S_SHIFT;
            end
          end
          default: state_d = S_DONE;
        endcase
      end

      S_READW: begin
        ok_d    = 1'b1;
        rval_d  = VAL_W'(ram_rdata);
        state_d = S_DONE;
      end

      S_FIND: begin
        // compare the entry read last cycle while fetching the next one
        if (chk_q && ram_rdata == val_q) begin
          ok_d    = 1'b1;
          fidx_d  = cmp_idx_q[POS_W-1:0];
          chk_d   = 1'b0;
          state_d = S_DONE;
        end else if (dst_q < len_q) begin
          ram_ctl.re = 1'b1;
          ram_raddr  = AW'(dst_q);
          chk_d      = 1'b1;
          cmp_idx_d  = dst_q;
          dst_d      = nxt;
        end else begin
          chk_d   = 1'b0;
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        // write back the entry fetched last cycle, one slot over
        ram_ctl.we = wr_pend_q;
        if (cont) begin
          ram_ctl.re = 1'b1;
          ram_raddr  = AW'(nxt);
          wr_pend_d  = 1'b1;
          wr_addr_d  = AW'(dst_q);
          dst_d      = nxt;
        end else begin
          wr_pend_d = 1'b0;
          state_d   = S_FIN;
        end
      end

      S_FIN: begin
        if (step_down) begin
          ram_ctl.we = 1'b1;
          ram_waddr  = AW'(pos_ext);
          ram_wdata  = val_q;
          len_d      = len_q + CNT_W'(1);
        end else begin
          len_d = len_q - CNT_W'(1);
        end
        ok_d    = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.ok          = ok_q;
          out_d.found_index = fidx_q;
          out_d.read_value  = rval_q;
          out_d.count       = len_q;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      chk_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= wr_pend_d;
      chk_q       <= chk_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    dst_q     <= dst_d;
    cmp_idx_q <= cmp_idx_d;
    wr_addr_q <= wr_addr_d;
    ok_q      <= ok_d;
    fidx_q    <= fidx_d;
    rval_q    <= rval_d;
    out_q     <= out_d;
  end

  olt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered list table
// drives read, find, insert and delete items over valid/ready, keeps a
// shadow copy of the list and its capacity, and compares every result item
// field by field against the shadow's prediction
// ----------------------------------------------------------------------------

import olt_pkg::*;

// shadow copy of the list: predicts each result and holds it until it returns
class list_shadow;
  localparam int SLOTS = 1 << POS_W;

  logic [VAL_W-1:0] entries [SLOTS];
  int unsigned      length = 0;
  int unsigned      capacity = SLOTS;
  out_t             pending_results [$];
  int unsigned      mismatches = 0;
  int unsigned      results_seen = 0;
  int unsigned      ops_by_mode [4] = '{0, 0, 0, 0};
  int unsigned      ok_by_mode [4] = '{0, 0, 0, 0};
  int unsigned      full_refusals = 0;
  int unsigned      peak_length = 0;

  function void set_capacity(logic [CNT_W-1:0] cap);
    capacity = cap;
  endfunction

  // apply one accepted operation and queue the result it must produce
  function void apply_op(in_t op);
    out_t        res;
    int unsigned bound;
    int unsigned j;
    res = '0;
    bound = (capacity < SLOTS) ? capacity : SLOTS;
    case (op.mode)
      MODE_READ: begin
        if (op.position < length) begin
          res.ok = 1'b1;
          res.read_value = entries[op.position];
        end
      end
      MODE_FIND: begin
        for (j = 0; j < length; j++) begin
          if (!res.ok && entries[j] == op.value) begin
            res.ok = 1'b1;
            res.found_index = j[POS_W-1:0];
          end
        end
      end
      MODE_INSERT: begin
        if (length >= bound) full_refusals++;
        if (op.position <= length && length < bound) begin
          for (j = length; j > op.position; j--) entries[j] = entries[j-1];
          entries[op.position] = op.value;
          length++;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (op.position < length) begin
          for (j = op.position; j + 1 < length; j++) entries[j] = entries[j+1];
          length--;
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = length[CNT_W-1:0];
    if (length > peak_length) peak_length = length;
    ops_by_mode[op.mode]++;
    if (res.ok) ok_by_mode[op.mode]++;
    pending_results.push_back(res);
  endfunction

  function void flag_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  function void compare_result(out_t got);
    out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result item with nothing pending, expected none, got %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    flag_field("ok", want.ok, got.ok);
    flag_field("found_index", want.found_index, got.found_index);
    flag_field("read_value", want.read_value, got.read_value);
    flag_field("count", want.count, got.count);
  endfunction
endclass

module tb_top;

  localparam int SLOTS        = 1 << POS_W;
  localparam int LIMIT_CYCLES = 600000;
  // longest op is a find or shift over the whole list
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 150;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;

  list_shadow  shadow_list;
  // idle odds, in percent of cycles, for the sender and the receiver
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;

  ordered_list_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver side: check each result item taken, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) shadow_list.compare_result(out_data_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending", $time,
               cycle_count, shadow_list.pending_results.size());
      $display("** ordered_list_table: FAILED **");
      $finish;
    end
  end

  // one item on the in channel; entered and left at a rising edge, valid left
  // high so a back-to-back item never drops it
  task automatic send_op(input mode_e m, input int unsigned pos, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_data_i.mode     <= m;
    in_data_i.position <= pos[POS_W-1:0];
    in_data_i.value    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    shadow_list.apply_op(in_data_i);
  endtask

  // let every pending result come home, then write the capacity register
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (shadow_list.pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_list.set_capacity(cap);
    cfg_valid_i <= 1'b0;
  endtask

  // random traffic that swings the list between empty and full: a grow trend
  // is mostly inserts, a shrink trend mostly deletes, and most positions and
  // find values are picked to land on the live part of the list
  task automatic run_list_phase(input int unsigned n_items);
    mode_e            m;
    int unsigned      pos;
    logic [VAL_W-1:0] val;
    int unsigned      roll;
    int unsigned      bound;
    int unsigned      len;
    bit               grow;
    grow = 1'b1;
    repeat (n_items) begin
      len   = shadow_list.length;
      bound = (shadow_list.capacity < SLOTS) ? shadow_list.capacity : SLOTS;
      if (len == 0) grow = 1'b1;
      else if (len >= bound) grow = 1'b0;
      else if ($urandom_range(99) < 3) grow = !grow;
      // small pool of values makes duplicates for find
      val  = ($urandom_range(99) < 30) ? $urandom_range(7) : $urandom;
      pos  = $urandom_range(SLOTS - 1);
      roll = $urandom_range(99);
      if (roll < 15) begin
        m = MODE_READ;
        if (len != 0 && $urandom_range(99) < 80) pos = $urandom_range(len - 1);
      end else if (roll < 30) begin
        m = MODE_FIND;
        if (len != 0 && $urandom_range(99) < 60)
          val = shadow_list.entries[$urandom_range(len - 1)];
      end else if (roll < (grow ? 95 : 35)) begin
        m = MODE_INSERT;
        // range includes the append slot just past the last entry
        if ($urandom_range(99) < 85) pos = $urandom_range(len < SLOTS - 1 ? len : SLOTS - 1);
      end else begin
        m = MODE_DELETE;
        if (len != 0 && $urandom_range(99) < 85) pos = $urandom_range(len - 1);
      end
      send_op(m, pos, val);
    end
  endtask

  initial begin
    shadow_list   = new();
    cycle_count   = 0;
    send_idle_pct = 22;
    recv_idle_pct = 51;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    out_ready_i   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_capacity(7'd64);

    // directed: empty list, front/middle/end inserts, reads and deletes on
    // both sides of the last entry, find hit, miss and first of duplicates
    send_op(MODE_READ,   0,  32'h0);
    send_op(MODE_DELETE, 0,  32'h0);
    send_op(MODE_FIND,   0,  32'h0);
    send_op(MODE_INSERT, 1,  32'hDEAD_BEEF);   // past the end of an empty list
    send_op(MODE_INSERT, 0,  32'hFFFF_FFFF);
    send_op(MODE_INSERT, 1,  32'h0000_0000);   // append
    send_op(MODE_INSERT, 0,  32'hA5A5_5A5A);   // front, shifts all up
    send_op(MODE_INSERT, 2,  32'h0000_0001);   // middle
    send_op(MODE_READ,   0,  32'h0);
    send_op(MODE_READ,   3,  32'h0);
    send_op(MODE_READ,   4,  32'h0);           // one past the last entry
    send_op(MODE_READ,   63, 32'h0);
    send_op(MODE_FIND,   0,  32'h0000_0000);
    send_op(MODE_FIND,   0,  32'hFFFF_FFFF);
    send_op(MODE_FIND,   0,  32'h1234_5678);   // miss
    send_op(MODE_INSERT, 63, 32'h5A5A_A5A5);   // position far past the end
    send_op(MODE_INSERT, 0,  32'h0000_0000);   // duplicate at the front
    send_op(MODE_FIND,   9,  32'h0000_0000);   // must report the first match
    send_op(MODE_DELETE, 5,  32'h0);           // one past the last entry
    send_op(MODE_DELETE, 63, 32'h0);
    send_op(MODE_DELETE, 4,  32'h0);           // last entry
    send_op(MODE_DELETE, 0,  32'h0);           // front
    send_op(MODE_DELETE, 1,  32'h0);           // middle
    run_list_phase(PHASE_ITEMS);

    // capacity above the table depth is clamped to the depth
    write_capacity(7'd127);
    run_list_phase(PHASE_ITEMS);

    // swap idling, then shrink capacity, likely below the current length
    send_idle_pct = 51;
    recv_idle_pct = 22;
    write_capacity(7'd5);
    run_list_phase(PHASE_ITEMS);
    write_capacity(7'd0);
    run_list_phase(PHASE_ITEMS);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(7'd1);
    run_list_phase(PHASE_ITEMS);
    write_capacity(7'd63);
    run_list_phase(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (shadow_list.pending_results.size() != 0) @(posedge clk_i);
    // catch any stray result item after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d reads, %0d finds, %0d inserts, %0d deletes; %0d results checked",
             shadow_list.ops_by_mode[MODE_READ], shadow_list.ops_by_mode[MODE_FIND],
             shadow_list.ops_by_mode[MODE_INSERT], shadow_list.ops_by_mode[MODE_DELETE],
             shadow_list.results_seen);
    $display("list grew to %0d entries, %0d inserts refused as full, capacity 64/127/5/0/1/63",
             shadow_list.peak_length, shadow_list.full_refusals);
    if (shadow_list.mismatches == 0) begin
      $display("** ordered_list_table: PASSED **");
    end else begin
      $display("** ordered_list_table: FAILED **");
    end
    $finish;
  end

endmodule
